/* design/cdsf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdsf_pkg
// Shared types, codes and encoding tables for the clock/date segment encoder.
// ----------------------------------------------------------------------------
package cdsf_pkg;

    // Request type codes.
    localparam logic [1:0] REQ_TIME      = 2'd0;
    localparam logic [1:0] REQ_DATE      = 2'd1;
    localparam logic [1:0] REQ_INTENSITY = 2'd2;

    // Intensity level that blanks the display.
    localparam logic [7:0] LEVEL_BLANK = 8'd3;

    localparam logic [7:0] SEG_DASH = 8'h01;
    localparam logic [7:0] SEG_DP   = 8'h80;
    localparam logic [7:0] SEG_OFF  = 8'h00;

    localparam logic [3:0] INTENSITY_REG = 4'hA;
    localparam logic [3:0] NO_REG        = 4'h0;

    localparam logic [6:0]  MAX_TWO_DIGIT = 7'd99;
    localparam logic [13:0] MAX_YEAR      = 14'd9999;

    localparam int NUM_DIGITS  = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        K_TIME,
        K_DATE,
        K_BLANK,
        K_BRIGHT
    } t_kind;

    // One classified request as it waits for the word sequencer.
    typedef struct packed {
        t_kind                            kind;
        logic [NUM_DIGITS-1:0][7:0]       pats;
    } t_entry;

    function automatic logic [7:0] seg_of(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'h7e;
            4'd1:    seg = 8'h30;
            4'd2:    seg = 8'h6d;
            4'd3:    seg = 8'h79;
            4'd4:    seg = 8'h33;
            4'd5:    seg = 8'h5b;
            4'd6:    seg = 8'h5f;
            4'd7:    seg = 8'h70;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h7b;
            default: seg = SEG_OFF;
        endcase
        return seg;
    endfunction

    function automatic logic [7:0] bright_of(input logic [7:0] level);
        logic [7:0] val;
        case (level)
            8'd0:    val = 8'h0a;
            8'd1:    val = 8'h05;
            8'd2:    val = 8'h00;
            8'd4:    val = 8'h0f;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

/* design/cdsf_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdsf_front
// Accepts requests, classifies them and turns the fields into segment
// patterns over three pipeline stages before handing them to the queue.
// ----------------------------------------------------------------------------
module cdsf_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output logic                       o_full,
    input  wire logic [1:0]            i_req_type,
    input  wire logic [6:0]            i_hour,
    input  wire logic [6:0]            i_minute,
    input  wire logic [6:0]            i_second,
    input  wire logic [6:0]            i_day,
    input  wire logic [6:0]            i_month,
    input  wire logic [13:0]           i_year,
    input  wire logic [7:0]            i_level,
    input  wire logic                  i_q_full,
    output logic                       o_q_push,
    output cdsf_pkg::t_entry           o_q_entry
);

    logic                  en;
    logic                  accept;
    logic                  cls_valid;
    cdsf_pkg::t_kind       cls_kind;
    logic [6:0]            sat_a;
    logic [6:0]            sat_b;
    logic [6:0]            sat_c;
    logic [13:0]           sat_y;
    logic [26:0]           y_prod;
    logic [13:0]           hi_x100;
    logic [13:0]           y_lo;
    logic [3:0][14:0]      tens_prod;
    logic [3:0][3:0]       tens;
    logic [3:0][3:0]       units;
    cdsf_pkg::t_entry      n_entry3;

    logic                  r_v1;
    logic                  r_v2;
    logic                  r_v3;
    cdsf_pkg::t_kind       r_kind1;
    cdsf_pkg::t_kind       r_kind2;
    logic [2:0][6:0]       r_val1;
    logic [13:0]           r_y1;
    logic [3:0][6:0]       r_val2;
    cdsf_pkg::t_entry      r_entry3;

    // The whole pipeline moves together; it holds only when its last stage
    // cannot be written into the queue.
    assign en       = !r_v3 || !i_q_full;
    assign o_full   = !en;
    assign accept   = i_push && en;
    assign o_q_push = r_v3 && !i_q_full;
    assign o_q_entry = r_entry3;

    // Classification and saturation.
    always_comb begin
        cls_valid = 1'b0;
        cls_kind  = cdsf_pkg::K_TIME;
        sat_a     = 7'd0;
        sat_b     = 7'd0;
        sat_c     = 7'd0;
        case (i_req_type)
            cdsf_pkg::REQ_TIME: begin
                cls_valid = 1'b1;
                cls_kind  = cdsf_pkg::K_TIME;
                sat_a = (i_hour   > cdsf_pkg::MAX_TWO_DIGIT) ? cdsf_pkg::MAX_TWO_DIGIT : i_hour;
                sat_b = (i_minute > cdsf_pkg::MAX_TWO_DIGIT) ? cdsf_pkg::MAX_TWO_DIGIT : i_minute;
                sat_c = (i_second > cdsf_pkg::MAX_TWO_DIGIT) ? cdsf_pkg::MAX_TWO_DIGIT : i_second;
            end
            cdsf_pkg::REQ_DATE: begin
                cls_valid = 1'b1;
                cls_kind  = cdsf_pkg::K_DATE;
                sat_a = (i_day   > cdsf_pkg::MAX_TWO_DIGIT) ? cdsf_pkg::MAX_TWO_DIGIT : i_day;
                sat_b = (i_month > cdsf_pkg::MAX_TWO_DIGIT) ? cdsf_pkg::MAX_TWO_DIGIT : i_month;
            end
            cdsf_pkg::REQ_INTENSITY: begin
                if (i_level == cdsf_pkg::LEVEL_BLANK) begin
                    cls_valid = 1'b1;
                    cls_kind  = cdsf_pkg::K_BLANK;
                end else if (i_level inside {8'd0, 8'd1, 8'd2, 8'd4}) begin
                    cls_valid = 1'b1;
                    cls_kind  = cdsf_pkg::K_BRIGHT;
                    sat_a     = 7'(cdsf_pkg::bright_of(i_level));
                end
            end
            default: begin
                cls_valid = 1'b0;
            end
        endcase
    end

    // Year hundreds: y / 100 as a multiply by a scaled reciprocal, exact
    // over the saturated range.
    assign sat_y  = (i_year > cdsf_pkg::MAX_YEAR) ? cdsf_pkg::MAX_YEAR : i_year;
    assign y_prod = 27'(sat_y) * 27'd5243;

    // Stage two: year below one hundred, hundreds times 100 by shifts.
    assign hi_x100 = (14'(r_val1[2]) << 6) + (14'(r_val1[2]) << 5)
                   + (14'(r_val1[2]) << 2);
    assign y_lo    = r_y1 - hi_x100;

    // Stage three: split every two-digit value and look up its pattern.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            tens_prod[k] = 15'(r_val2[k]) * 15'd205;
            tens[k]      = tens_prod[k][14:11];
            units[k]     = 4'(r_val2[k] - ((7'(tens[k]) << 3) + (7'(tens[k]) << 1)));
        end
        n_entry3.kind = r_kind2;
        n_entry3.pats = '0;
        case (r_kind2)
            cdsf_pkg::K_TIME: begin
                n_entry3.pats[0] = cdsf_pkg::seg_of(tens[0]);
                n_entry3.pats[1] = cdsf_pkg::seg_of(units[0]);
                n_entry3.pats[2] = cdsf_pkg::SEG_DASH;
                n_entry3.pats[3] = cdsf_pkg::seg_of(tens[1]);
                n_entry3.pats[4] = cdsf_pkg::seg_of(units[1]);
                n_entry3.pats[5] = cdsf_pkg::SEG_DASH;
                n_entry3.pats[6] = cdsf_pkg::seg_of(tens[2]);
                n_entry3.pats[7] = cdsf_pkg::seg_of(units[2]);
            end
            cdsf_pkg::K_DATE: begin
                n_entry3.pats[0] = cdsf_pkg::seg_of(tens[0]);
                n_entry3.pats[1] = cdsf_pkg::seg_of(units[0]) | cdsf_pkg::SEG_DP;
                n_entry3.pats[2] = cdsf_pkg::seg_of(tens[1]);
                n_entry3.pats[3] = cdsf_pkg::seg_of(units[1]) | cdsf_pkg::SEG_DP;
                n_entry3.pats[4] = cdsf_pkg::seg_of(tens[2]);
                n_entry3.pats[5] = cdsf_pkg::seg_of(units[2]);
                n_entry3.pats[6] = cdsf_pkg::seg_of(tens[3]);
                n_entry3.pats[7] = cdsf_pkg::seg_of(units[3]);
            end
            cdsf_pkg::K_BRIGHT: begin
                n_entry3.pats[0] = {1'b0, r_val2[0]};
            end
            default: begin
                n_entry3.pats = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= accept && cls_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kind1   <= cls_kind;
            r_val1[0] <= sat_a;
            r_val1[1] <= sat_b;
            r_val1[2] <= (i_req_type == cdsf_pkg::REQ_DATE) ? y_prod[25:19] : sat_c;
            r_y1      <= sat_y;

            r_kind2   <= r_kind1;
            r_val2[0] <= r_val1[0];
            r_val2[1] <= r_val1[1];
            r_val2[2] <= r_val1[2];
            r_val2[3] <= y_lo[6:0];

            r_entry3  <= n_entry3;
        end
    end

endmodule
`default_nettype wire

/* design/cdsf_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdsf_queue
// Short register queue of classified requests between front and back.
// ----------------------------------------------------------------------------
module cdsf_queue #(
    parameter int DEPTH = cdsf_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire cdsf_pkg::t_entry  i_entry,
    output logic                   o_full,
    output logic                   o_valid,
    output cdsf_pkg::t_entry       o_head,
    input  wire logic              i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cdsf_pkg::t_entry   r_mem [DEPTH];
    logic [AW-1:0]      r_wr;
    logic [AW-1:0]      r_rd;
    logic [CW-1:0]      r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule
`default_nettype wire

/* design/cdsf_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// cdsf_back
// Word sequencer: walks the head request one word per cycle, while the output
// stage is empty or its word is taken, into a registered output stage.
// ----------------------------------------------------------------------------
module cdsf_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire cdsf_pkg::t_entry  i_q_head,
    output logic                   o_q_pop,
    output logic                   o_empty,
    input  wire logic              i_pop,
    output logic [3:0]             o_digit_register,
    output logic [7:0]             o_segment_pattern,
    output logic                   o_last
);

    logic          load;
    logic [3:0]    w_reg;
    logic [7:0]    w_pat;
    logic          w_last;

    logic          r_out_valid;
    logic [2:0]    r_idx;
    logic [3:0]    r_reg;
    logic [7:0]    r_pat;
    logic          r_last;

    // A new word enters the output stage whenever the queue has a head and the
    // stage is empty or its word is being taken in this cycle.
    assign load    = i_q_valid && (!r_out_valid || i_pop);
    assign o_q_pop = load && w_last;
    assign o_empty = !r_out_valid;
    assign o_digit_register  = r_reg;
    assign o_segment_pattern = r_pat;
    assign o_last            = r_last;

    always_comb begin
        case (i_q_head.kind)
            cdsf_pkg::K_TIME, cdsf_pkg::K_DATE: begin
                w_reg  = 4'd8 - {1'b0, r_idx};
                w_pat  = i_q_head.pats[r_idx];
                w_last = (r_idx == 3'(cdsf_pkg::NUM_DIGITS - 1));
            end
            cdsf_pkg::K_BLANK: begin
                w_reg  = {1'b0, r_idx} + 4'd1;
                w_pat  = cdsf_pkg::SEG_OFF;
                w_last = (r_idx == 3'(cdsf_pkg::NUM_DIGITS - 1));
            end
            cdsf_pkg::K_BRIGHT: begin
                w_reg  = cdsf_pkg::INTENSITY_REG;
                w_pat  = i_q_head.pats[0];
                w_last = 1'b1;
            end
            default: begin
                w_reg  = cdsf_pkg::NO_REG;
                w_pat  = cdsf_pkg::SEG_OFF;
                w_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= w_last ? 3'd0 : r_idx + 3'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_reg  <= w_reg;
            r_pat  <= w_pat;
            r_last <= w_last;
        end
    end

endmodule
`default_nettype wire

/* design/clock_date_segment_frame_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// clock_date_segment_frame_encoder
// Turns time, date and intensity requests into register-write words for an
// eight-digit seven-segment display driver.
// ----------------------------------------------------------------------------
//  Channel   | Handshake     | Payload
//  ----------+---------------+------------------------------------------------
//  request   | i_push/o_full | i_req_type, i_hour .. i_year, i_level
//  word      | o_empty/i_pop | o_digit_register, o_segment_pattern, o_last
//
// A request passes a three-stage front pipeline, then waits in a short
// queue; the sequencer sends one word per cycle while the output is taken,
// eight words for a time, date or blank request and one for brightness.
// With an idle output the first word goes through the front stages, the
// queue and the registered output stage before it reaches the outputs.
// Requests that produce no word are dropped in the front.
// Reset is synchronous; a held output stalls the sequencer, a full queue
// stalls the front and raises o_full once the front's last stage is full.
// ----------------------------------------------------------------------------
module clock_date_segment_frame_encoder #(
    parameter int QDEPTH = cdsf_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire logic [1:0]    i_req_type,
    input  wire logic [6:0]    i_hour,
    input  wire logic [6:0]    i_minute,
    input  wire logic [6:0]    i_second,
    input  wire logic [6:0]    i_day,
    input  wire logic [6:0]    i_month,
    input  wire logic [13:0]   i_year,
    input  wire logic [7:0]    i_level,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [3:0]         o_digit_register,
    output logic [7:0]         o_segment_pattern,
    output logic               o_last
);

    logic              q_push;
    cdsf_pkg::t_entry  q_in;
    logic              q_full;
    logic              q_valid;
    cdsf_pkg::t_entry  q_head;
    logic              q_pop;

    cdsf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_req_type (i_req_type),
        .i_hour     (i_hour),
        .i_minute   (i_minute),
        .i_second   (i_second),
        .i_day      (i_day),
        .i_month    (i_month),
        .i_year     (i_year),
        .i_level    (i_level),
        .i_q_full   (q_full),
        .o_q_push   (q_push),
        .o_q_entry  (q_in)
    );

    cdsf_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    cdsf_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_head          (q_head),
        .o_q_pop           (q_pop),
        .o_empty           (o_empty),
        .i_pop             (i_pop),
        .o_digit_register  (o_digit_register),
        .o_segment_pattern (o_segment_pattern),
        .o_last            (o_last)
    );

endmodule
`default_nettype wire
